// ===== hdl/amiv_pkg.sv =====
// ----------------------------------------------------------------------------
// amiv_pkg
// Shared widths, index tables and divider stage type for the affine 3x4
// matrix inverse.
// ----------------------------------------------------------------------------
package amiv_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int IDX_BITS   = 4;
   localparam int NUM_ELEMS  = 12;
   localparam int LAST_IDX   = 11;
   localparam int NUM_COF    = 9;
   localparam int NUM_PROD   = 12;

   localparam int PROD_W = 2 * WORD_BITS;
   localparam int COF_W  = 2 * WORD_BITS + 1;
   localparam int PP_W   = 2 * WORD_BITS + 1;
   localparam int TP_W   = 3 * WORD_BITS + 1;
   localparam int SUM_W  = 3 * WORD_BITS + 3;
   localparam int TNUM_W = SUM_W + 1 + FRAC_BITS;
   localparam int LNUM_W = COF_W + 2 * FRAC_BITS;
   localparam int NUM_W  = (TNUM_W > LNUM_W) ? TNUM_W : LNUM_W;
   localparam int AD_W   = SUM_W;
   localparam int DD_W   = AD_W + 1;
   localparam int N_W    = ((NUM_W > AD_W) ? NUM_W : AD_W) + 2;
   localparam int NH_W   = N_W - WORD_BITS;
   localparam int CMP_W  = (NH_W > DD_W) ? NH_W : DD_W;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [IDX_BITS-1:0]         elem_idx_type;

   // cofactor j = m[a]*m[b] - m[c]*m[d]
   localparam int COF_SEL [NUM_COF][4] = '{
      '{5, 10, 9, 6}, '{9, 2, 1, 10}, '{1, 6, 5, 2},
      '{8, 6, 4, 10}, '{0, 10, 8, 2}, '{4, 2, 0, 6},
      '{4, 9, 8, 5},  '{8, 1, 0, 9},  '{0, 5, 4, 1}
   };

   // products: three determinant terms, then nine translation terms
   localparam int PM_M [NUM_PROD] = '{0, 1, 2, 3, 7, 11, 3, 7, 11, 3, 7, 11};
   localparam int PM_C [NUM_PROD] = '{0, 3, 6, 0, 1, 2, 3, 4, 5, 6, 7, 8};

   typedef struct packed {
      logic [DD_W-1:0]      rem;
      logic [DD_W-1:0]      den;
      logic [WORD_BITS-1:0] nlo;
      logic [WORD_BITS-1:0] quo;
      logic                 ovf;
      logic                 neg;
      logic                 sing;
      elem_idx_type         idx;
      logic                 last;
   } div_stage_type;

   function automatic div_stage_type div_step(div_stage_type s);
      logic [DD_W:0] trial;
      logic          ge;
      div_stage_type r;
      trial = {s.rem, s.nlo[WORD_BITS-1]};
      ge    = (trial >= {1'b0, s.den});
      r     = s;
      r.rem = ge ? DD_W'(trial - {1'b0, s.den}) : DD_W'(trial);
      r.nlo = {s.nlo[WORD_BITS-2:0], 1'b0};
      r.quo = {s.quo[WORD_BITS-2:0], ge};
      return r;
   endfunction

endpackage

// ===== hdl/amiv_req_if.sv =====
// ----------------------------------------------------------------------------
// amiv_req_if
// Request channel: one 3x4 affine matrix per transaction.
// ----------------------------------------------------------------------------
interface amiv_req_if;
   import amiv_pkg::*;

   logic     valid;
   logic     ready;
   word_type r0c0, r0c1, r0c2, r0c3;
   word_type r1c0, r1c1, r1c2, r1c3;
   word_type r2c0, r2c1, r2c2, r2c3;

   modport source (
      output valid, r0c0, r0c1, r0c2, r0c3, r1c0, r1c1, r1c2, r1c3,
             r2c0, r2c1, r2c2, r2c3,
      input  ready
   );
   modport sink (
      input  valid, r0c0, r0c1, r0c2, r0c3, r1c0, r1c1, r1c2, r1c3,
             r2c0, r2c1, r2c2, r2c3,
      output ready
   );
endinterface

// ===== hdl/amiv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// amiv_rsp_if
// Response channel: one inverse element per transaction.
// ----------------------------------------------------------------------------
interface amiv_rsp_if;
   import amiv_pkg::*;

   logic         valid;
   logic         ready;
   elem_idx_type elem_index;
   word_type     elem_value;
   logic         singular;
   logic         last;

   modport source (output valid, elem_index, elem_value, singular, last, input ready);
   modport sink   (input valid, elem_index, elem_value, singular, last, output ready);
endinterface

// ===== hdl/affine_matrix_inverse.sv =====
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Inverts a 3x4 affine transform in signed Q16.16.
//
// req_chan takes one matrix per transaction (twelve elements, row-major,
// column 3 is the translation). rsp_chan returns the twelve inverse elements
// as separate transactions, indices 0..11 in order, last on index 11.
// Each element is the exact quotient rounded to nearest (ties away from
// zero) and saturated; a zero determinant gives zeros with singular set.
// Throughput: one element per cycle while rsp_chan does not stall; the
// element serializer in front of the divider sets that rate.
// The front end (products, cofactors, determinant, numerators) is six
// stages; the divider is fully pipelined, one quotient bit per stage.
// Reset clears all valid bits; no transaction is in flight afterwards.
// When rsp_chan stalls, every stage holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module affine_matrix_inverse (
   input logic         clock,
   input logic         reset,
   amiv_req_if.sink    req_chan,
   amiv_rsp_if.source  rsp_chan
);
   import amiv_pkg::*;

   logic adv, front_adv, ser_slot, ser_done;

   word_type in_m [NUM_ELEMS];

   logic     s0_v_ff;
   word_type s0_m_ff [NUM_ELEMS];

   logic                     s1_v_ff;
   word_type                 s1_m_ff [NUM_ELEMS];
   logic signed [PROD_W-1:0] s1_pa_ff [NUM_COF];
   logic signed [PROD_W-1:0] s1_pb_ff [NUM_COF];

   logic                    s2_v_ff;
   word_type                s2_m_ff [NUM_ELEMS];
   logic signed [COF_W-1:0] s2_cof_ff [NUM_COF];

   logic                    s3_v_ff;
   logic signed [COF_W-1:0] s3_cof_ff [NUM_COF];
   logic signed [PP_W-1:0]  s3_plo_ff [NUM_PROD];
   logic signed [PP_W-1:0]  s3_phi_ff [NUM_PROD];

   logic                    s4_v_ff;
   logic signed [COF_W-1:0] s4_cof_ff [NUM_COF];
   logic signed [TP_W-1:0]  s4_prod_ff [NUM_PROD];

   logic                    s5_v_ff;
   logic signed [SUM_W-1:0] s5_det_ff, s5_det_in;
   logic signed [NUM_W-1:0] s5_num_ff [NUM_ELEMS];
   logic signed [NUM_W-1:0] s5_num_in [NUM_ELEMS];

   logic                    ser_v_ff;
   elem_idx_type            ser_cnt_ff;
   logic signed [SUM_W-1:0] ser_det_ff;
   logic signed [NUM_W-1:0] ser_num_ff [NUM_ELEMS];
   logic signed [NUM_W-1:0] sel_num;

   logic             dv0_v_ff;
   logic [NUM_W-1:0] dv0_an_ff;
   logic [AD_W-1:0]  dv0_ad_ff;
   logic             dv0_neg_ff, dv0_sing_ff, dv0_last_ff;
   elem_idx_type     dv0_idx_ff;

   logic [N_W-1:0]   num2_in;
   logic [CMP_W-1:0] nh_in;
   div_stage_type    st0_in;

   logic          st_v_ff [WORD_BITS+1];
   div_stage_type st_ff   [WORD_BITS+1];

   div_stage_type        fin;
   logic [WORD_BITS-1:0] lim, mag;
   word_type             value_in;

   logic         rsp_v_ff;
   elem_idx_type rsp_idx_ff;
   word_type     rsp_val_ff;
   logic         rsp_sing_ff, rsp_last_ff;

   assign in_m = '{req_chan.r0c0, req_chan.r0c1, req_chan.r0c2, req_chan.r0c3,
                   req_chan.r1c0, req_chan.r1c1, req_chan.r1c2, req_chan.r1c3,
                   req_chan.r2c0, req_chan.r2c1, req_chan.r2c2, req_chan.r2c3};

   assign adv       = !rsp_v_ff || rsp_chan.ready;
   assign ser_done  = ser_v_ff && (ser_cnt_ff == IDX_BITS'(LAST_IDX));
   assign ser_slot  = !ser_v_ff || ser_done;
   assign front_adv = adv && (!s5_v_ff || ser_slot);
   assign req_chan.ready = front_adv;

   // front end valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (front_adv) begin
         s0_v_ff <= req_chan.valid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   always_comb begin
      logic signed [SUM_W:0] acc;
      s5_det_in = SUM_W'(s4_prod_ff[0]) + SUM_W'(s4_prod_ff[1]) + SUM_W'(s4_prod_ff[2]);
      for (int r = 0; r < 3; r++) begin
         acc = -((SUM_W+1)'(s4_prod_ff[3+3*r]) + (SUM_W+1)'(s4_prod_ff[4+3*r])
                 + (SUM_W+1)'(s4_prod_ff[5+3*r]));
         for (int c = 0; c < 3; c++) begin
            s5_num_in[r*4+c] = NUM_W'(s4_cof_ff[r*3+c]) <<< (2 * FRAC_BITS);
         end
         s5_num_in[r*4+3] = NUM_W'(acc) <<< FRAC_BITS;
      end
   end

   // front end data path
   always_ff @(posedge clock) begin
      if (front_adv) begin
         s0_m_ff <= in_m;
         s1_m_ff <= s0_m_ff;
         for (int j = 0; j < NUM_COF; j++) begin
            s1_pa_ff[j] <= PROD_W'(s0_m_ff[COF_SEL[j][0]]) * PROD_W'(s0_m_ff[COF_SEL[j][1]]);
            s1_pb_ff[j] <= PROD_W'(s0_m_ff[COF_SEL[j][2]]) * PROD_W'(s0_m_ff[COF_SEL[j][3]]);
            s2_cof_ff[j] <= COF_W'(s1_pa_ff[j]) - COF_W'(s1_pb_ff[j]);
         end
         s2_m_ff   <= s1_m_ff;
         s3_cof_ff <= s2_cof_ff;
         for (int j = 0; j < NUM_PROD; j++) begin
            s3_plo_ff[j] <= PP_W'(s2_m_ff[PM_M[j]])
                            * PP_W'($signed({1'b0, s2_cof_ff[PM_C[j]][WORD_BITS-1:0]}));
            s3_phi_ff[j] <= PP_W'(s2_m_ff[PM_M[j]])
                            * PP_W'($signed(s2_cof_ff[PM_C[j]][COF_W-1:WORD_BITS]));
            s4_prod_ff[j] <= (TP_W'(s3_phi_ff[j]) <<< WORD_BITS) + TP_W'(s3_plo_ff[j]);
         end
         s4_cof_ff <= s3_cof_ff;
         s5_det_ff <= s5_det_in;
         s5_num_ff <= s5_num_in;
      end
   end

   // serializer: load a matrix when the previous one has sent its last element
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_v_ff   <= 1'b0;
         ser_cnt_ff <= '0;
      end else if (adv) begin
         if (ser_slot) begin
            ser_v_ff   <= s5_v_ff;
            ser_cnt_ff <= '0;
         end else begin
            ser_cnt_ff <= ser_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && ser_slot) begin
         ser_det_ff <= s5_det_ff;
         ser_num_ff <= s5_num_ff;
      end
   end

   assign sel_num = ser_num_ff[ser_cnt_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv0_v_ff <= 1'b0;
      end else if (adv) begin
         dv0_v_ff <= ser_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv0_an_ff   <= sel_num[NUM_W-1] ? NUM_W'(-sel_num) : NUM_W'(sel_num);
         dv0_ad_ff   <= ser_det_ff[SUM_W-1] ? AD_W'(-ser_det_ff) : AD_W'(ser_det_ff);
         dv0_neg_ff  <= sel_num[NUM_W-1] ^ ser_det_ff[SUM_W-1];
         dv0_sing_ff <= (ser_det_ff == '0);
         dv0_idx_ff  <= ser_cnt_ff;
         dv0_last_ff <= ser_done;
      end
   end

   // rounded quotient: floor((2|n| + |d|) / (2|d|))
   always_comb begin
      num2_in     = (N_W'(dv0_an_ff) << 1) + N_W'(dv0_ad_ff);
      nh_in       = CMP_W'(num2_in[N_W-1:WORD_BITS]);
      st0_in.den  = DD_W'(dv0_ad_ff) << 1;
      st0_in.ovf  = (nh_in >= CMP_W'(st0_in.den));
      st0_in.rem  = nh_in[DD_W-1:0];
      st0_in.nlo  = num2_in[WORD_BITS-1:0];
      st0_in.quo  = '0;
      st0_in.neg  = dv0_neg_ff;
      st0_in.sing = dv0_sing_ff;
      st0_in.idx  = dv0_idx_ff;
      st0_in.last = dv0_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= WORD_BITS; k++) begin
            st_v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         st_v_ff[0] <= dv0_v_ff;
         for (int k = 0; k < WORD_BITS; k++) begin
            st_v_ff[k+1] <= st_v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st0_in;
         for (int k = 0; k < WORD_BITS; k++) begin
            st_ff[k+1] <= div_step(st_ff[k]);
         end
      end
   end

   // saturate, apply sign, force zero when singular
   always_comb begin
      fin = st_ff[WORD_BITS];
      lim = fin.neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
      mag = (fin.ovf || fin.quo > lim) ? lim : fin.quo;
      if (fin.sing) begin
         value_in = '0;
      end else if (fin.neg) begin
         value_in = $signed(-mag);
      end else begin
         value_in = $signed(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= st_v_ff[WORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_idx_ff  <= fin.idx;
         rsp_val_ff  <= value_in;
         rsp_sing_ff <= fin.sing;
         rsp_last_ff <= fin.last;
      end
   end

   assign rsp_chan.valid      = rsp_v_ff;
   assign rsp_chan.elem_index = rsp_idx_ff;
   assign rsp_chan.elem_value = rsp_val_ff;
   assign rsp_chan.singular   = rsp_sing_ff;
   assign rsp_chan.last       = rsp_last_ff;

   a_last_on_final : assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_last_ff == (rsp_idx_ff == IDX_BITS'(LAST_IDX))))
      else $error("last flag does not match final element index");

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_sing_ff) |-> (rsp_val_ff == '0))
      else $error("singular element with nonzero value");

   a_ser_count : assert property (@(posedge clock) disable iff (reset)
      ser_v_ff |-> (ser_cnt_ff <= IDX_BITS'(LAST_IDX)))
      else $error("serializer count out of range");

   a_index_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_chan.ready && !rsp_last_ff) |=>
      (!rsp_v_ff || rsp_idx_ff == IDX_BITS'($past(rsp_idx_ff) + 1'b1)))
      else $error("element index out of order");

endmodule

// ===== tb/sv/amiv_inverse_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// amiv_inverse_checker
// Watches the request and response channels of the affine matrix inverse,
// computes the expected twelve inverse elements of every accepted matrix
// with exact wide integer arithmetic, and compares each response in order.
// ----------------------------------------------------------------------------
module amiv_inverse_checker
   import amiv_pkg::*;
(
   input  logic clock,
   amiv_req_if  req,
   amiv_rsp_if  rsp,
   output int   fail_count,
   output int   pending
);

   typedef logic signed [191:0] wide_type;

   typedef struct {
      elem_idx_type idx;
      word_type     value;
      logic         sing;
      logic         last;
   } inv_elem_type;

   inv_elem_type inverse_q[$];

   function automatic word_type round_quotient(wide_type num, wide_type den);
      logic neg;
      wide_type an, ad, q, lim;
      if (num == 0) return '0;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      q   = (2 * an + ad) / (2 * ad);
      lim = neg ? (wide_type'(1) <<< (WORD_BITS - 1))
                : (wide_type'(1) <<< (WORD_BITS - 1)) - 1;
      if (q > lim) q = lim;
      if (neg) q = -q;
      return word_type'(q[WORD_BITS-1:0]);
   endfunction

   task automatic push_inverse(input word_type w [12]);
      wide_type m [12];
      wide_type cof [9];
      wide_type det, tr;
      wide_type num [12];
      inv_elem_type e;
      for (int i = 0; i < 12; i++) m[i] = wide_type'(w[i]);
      cof[0] = m[5] * m[10] - m[9] * m[6];
      cof[1] = m[9] * m[2]  - m[1] * m[10];
      cof[2] = m[1] * m[6]  - m[5] * m[2];
      cof[3] = m[8] * m[6]  - m[4] * m[10];
      cof[4] = m[0] * m[10] - m[8] * m[2];
      cof[5] = m[4] * m[2]  - m[0] * m[6];
      cof[6] = m[4] * m[9]  - m[8] * m[5];
      cof[7] = m[8] * m[1]  - m[0] * m[9];
      cof[8] = m[0] * m[5]  - m[4] * m[1];
      det = m[0] * cof[0] + m[1] * cof[3] + m[2] * cof[6];
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) num[r*4+c] = cof[r*3+c] <<< (2 * FRAC_BITS);
         tr = cof[r*3] * m[3] + cof[r*3+1] * m[7] + cof[r*3+2] * m[11];
         num[r*4+3] = (-tr) <<< FRAC_BITS;
      end
      for (int i = 0; i < NUM_ELEMS; i++) begin
         e.idx   = elem_idx_type'(i);
         e.sing  = (det == 0);
         e.value = e.sing ? '0 : round_quotient(num[i], det);
         e.last  = (i == LAST_IDX);
         inverse_q.push_back(e);
      end
   endtask

   initial fail_count = 0;
   initial pending = 0;

   always @(posedge clock) begin
      inv_elem_type e;
      if (req.valid && req.ready)
         push_inverse('{req.r0c0, req.r0c1, req.r0c2, req.r0c3,
                        req.r1c0, req.r1c1, req.r1c2, req.r1c3,
                        req.r2c0, req.r2c1, req.r2c2, req.r2c3});
      if (rsp.valid && rsp.ready) begin
         if (inverse_q.size() == 0) begin
            $display("%0t: unexpected transaction idx=%0d value=%h sing=%b last=%b",
                     $time, rsp.elem_index, rsp.elem_value, rsp.singular, rsp.last);
            fail_count++;
         end else begin
            e = inverse_q.pop_front();
            if (rsp.elem_index !== e.idx || rsp.elem_value !== e.value ||
                rsp.singular !== e.sing || rsp.last !== e.last) begin
               $display("%0t: expected idx=%0d value=%h sing=%b last=%b", $time,
                        e.idx, e.value, e.sing, e.last);
               $display("%0t: actual   idx=%0d value=%h sing=%b last=%b", $time,
                        rsp.elem_index, rsp.elem_value, rsp.singular, rsp.last);
               fail_count++;
            end
         end
      end
      pending = inverse_q.size();
   end

endmodule

// ===== tb/sv/tb_affine_matrix_inverse.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_matrix_inverse
// Drives directed and random 3x4 affine matrices into the inverse block with
// bursty requests and a stalling receiver; the checker predicts and compares
// every inverse element, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_affine_matrix_inverse;
   import amiv_pkg::*;

   localparam word_type ONE  = 32'sh0001_0000;
   localparam word_type WMAX = 32'sh7fff_ffff;
   localparam word_type WMIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   gap_left = 0;

   amiv_req_if req_chan ();
   amiv_rsp_if rsp_chan ();

   affine_matrix_inverse uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   amiv_inverse_checker checker_i (
      .clock      (clock),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      {req_chan.r0c0, req_chan.r0c1, req_chan.r0c2, req_chan.r0c3} = '0;
      {req_chan.r1c0, req_chan.r1c1, req_chan.r1c2, req_chan.r1c3} = '0;
      {req_chan.r2c0, req_chan.r2c1, req_chan.r2c2, req_chan.r2c3} = '0;
      rsp_chan.ready = 1'b0;
   end

   // receiver stall pattern: ready drops at a randomly redrawn stall rate of 0, 25, 50 or 75 percent
   int unsigned stall_pct = 0;
   int unsigned cyc = 0;
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc % 64 == 0) stall_pct <= $urandom_range(0, 3) * 25;
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_matrix(input word_type m [12]);
      req_chan.valid <= 1'b1;
      req_chan.r0c0 <= m[0]; req_chan.r0c1 <= m[1];
      req_chan.r0c2 <= m[2]; req_chan.r0c3 <= m[3];
      req_chan.r1c0 <= m[4]; req_chan.r1c1 <= m[5];
      req_chan.r1c2 <= m[6]; req_chan.r1c3 <= m[7];
      req_chan.r2c0 <= m[8]; req_chan.r2c1 <= m[9];
      req_chan.r2c2 <= m[10]; req_chan.r2c3 <= m[11];
      do @(posedge clock); while (!req_chan.ready);
      // end of burst: maybe drop valid and idle, then draw a new burst length
      if (gap_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
         gap_left = $urandom_range(1, 6);
      end
      gap_left--;
   endtask

   function automatic word_type rand_small();
      return word_type'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
   endfunction

   function automatic word_type rand_full();
      return word_type'($urandom);
   endfunction

   initial begin
      word_type m [12];
      int kind;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      m = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0};              send_matrix(m);
      m = '{default: 0};                                            send_matrix(m);
      m = '{default: WMAX};                                         send_matrix(m);
      m = '{default: WMIN};                                         send_matrix(m);
      m = '{WMAX, 0, 0, WMIN, 0, WMAX, 0, WMAX, 0, 0, WMIN, WMIN};  send_matrix(m);
      m = '{WMIN, 0, 0, WMAX, 0, WMIN, 0, WMIN, 0, 0, WMIN, WMAX};  send_matrix(m);
      m = '{1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0};                    send_matrix(m);
      m = '{-1, 0, 0, ONE, 0, 1, 0, -ONE, 0, 0, -1, WMAX};          send_matrix(m);
      m = '{2*ONE, 0, 0, 1, 0, 2*ONE, 0, -1, 0, 0, 2*ONE, 3};       send_matrix(m);
      m = '{3*ONE, 0, 0, 0, 0, 3*ONE, 0, 0, 0, 0, 3*ONE, ONE};      send_matrix(m);
      m = '{0, ONE, 0, 5*ONE, ONE, 0, 0, -7*ONE, 0, 0, -ONE, ONE};  send_matrix(m);
      m = '{ONE, 2*ONE, 3*ONE, 1, 2*ONE, 4*ONE, 6*ONE, 2,
            -ONE, ONE, 0, 3};                                       send_matrix(m);
      m = '{ONE, ONE, 0, WMAX, ONE, ONE, 0, WMIN, 0, 0, ONE, 0};    send_matrix(m);
      m = '{ONE, 2, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, WMIN};           send_matrix(m);
      m = '{WMAX, WMIN, 1, -1, WMIN, WMAX, -1, 1, 1, -1, WMAX, WMIN}; send_matrix(m);
      m = '{-ONE, 0, 0, 0, 0, -ONE, 0, 0, 0, 0, -ONE, -ONE};        send_matrix(m);
      m = '{ONE/2, ONE/4, 0, ONE, 0, ONE/2, ONE/4, ONE, ONE/4, 0, ONE/2, ONE};
      send_matrix(m);

      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);

      for (int n = 0; n < 103; n++) begin
         kind = $urandom_range(0, 9);
         for (int i = 0; i < 12; i++)
            m[i] = (kind < 6) ? rand_small() : rand_full();
         if (kind < 6)
            for (int i = 0; i < 3; i++) m[i*5] = m[i*5] + 4 * ONE;
         if (kind >= 3 && kind < 6) begin
            m[3] = rand_full(); m[7] = rand_full(); m[11] = rand_full();
         end
         if (kind == 9)
            for (int c = 0; c < 3; c++) m[8+c] = m[c];
         send_matrix(m);
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);

      wait (pending == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
